[hdl/quaternion_yaw_tracker_defines.svh]
// ----------------------------------------------------------------------------
// Quaternion yaw tracker assertion macros
// Shared property wrappers for the tracker's checks.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_YAW_TRACKER_DEFINES_SVH
`define QUATERNION_YAW_TRACKER_DEFINES_SVH

// same-cycle implication
`define QYT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QYT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/qyt_pkg.sv]
// ----------------------------------------------------------------------------
// Quaternion yaw tracker package
// Command types, FIFO status codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package qyt_pkg;

  localparam logic [1:0] ST_DATA  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [15:0] YAW_HALF = 16'd23040;
  localparam logic [17:0] YAW_MAX  = 18'd46080;
  localparam logic [63:0] ONE_Q60  = 64'h1000_0000_0000_0000;
  localparam logic [63:0] ONE_Q59  = 64'h0800_0000_0000_0000;
  localparam logic signed [25:0] ANG_90  = 26'sd5898240;
  localparam logic signed [26:0] ANG_180 = 27'sd11796480;

  // atan(2^-i) in Q16 degrees
  localparam logic [23:0] ATAN_TBL [32] = '{
    24'd2949120, 24'd1740967, 24'd919879, 24'd466945,
    24'd234379,  24'd117304,  24'd58666,  24'd29335,
    24'd14668,   24'd7334,    24'd3667,   24'd1833,
    24'd917,     24'd458,     24'd229,    24'd115,
    24'd57,      24'd29,      24'd14,     24'd7,
    24'd4,       24'd2,       24'd1,      24'd0,
    24'd0,       24'd0,       24'd0,      24'd0,
    24'd0,       24'd0,       24'd0,      24'd0
  };

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_MUL,
    OP_RINIT,
    OP_ROOT,
    OP_WMUL,
    OP_OPER,
    OP_CINIT,
    OP_CORDIC,
    OP_FIN
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] step;
    logic       start;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

[hdl/quaternion_yaw_tracker.sv]
// ----------------------------------------------------------------------------
// Quaternion yaw tracker
// Rebuilds yaw from six-axis quaternion requests and reports a tracked heading
// on each FIFO-empty request.
//
//   channel | handshake             | payload
//   in      | in_valid / in_stall   | fifo_status, has_quat6, quat_x/y/z
//   out     | out_valid / out_stall | heading, current_yaw
//   cfg     | cfg_valid / cfg_ready | cfg_data (dead_band)
//
// A quaternion request passes through multiply, root setup, the bitwise square
// root, the w*z multiply, operand setup, CORDIC setup, CORDIC vectoring at one
// iteration per cycle and finish. Empty, status and non-quaternion requests are handled in idle.
// Reset is synchronous; no clearing pass. in_stall is high while a request
// is in work or while a result is held by out_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_yaw_tracker #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [1:0]          fifo_status,
  input  wire                 has_quat6,
  input  wire  signed [31:0]  quat_x,
  input  wire  signed [31:0]  quat_y,
  input  wire  signed [31:0]  quat_z,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic signed [31:0]  heading,
  output logic [15:0]         current_yaw,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [15:0]         cfg_data
);
  import qyt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  qyt_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .fifo_status (fifo_status),
    .has_quat6   (has_quat6),
    .stat        (stat),
    .cmd         (cmd)
  );

  qyt_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .quat_x      (quat_x),
    .quat_y      (quat_y),
    .quat_z      (quat_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .heading     (heading),
    .current_yaw (current_yaw)
  );

endmodule

`default_nettype wire

[hdl/qyt_datapath.sv]
// ----------------------------------------------------------------------------
// Quaternion yaw tracker datapath
// Shared multiplier, bitwise square root, CORDIC vectoring and heading update.
// ----------------------------------------------------------------------------
`default_nettype none

module qyt_datapath (
  input  wire                  clk,
  input  wire                  rst,
  input  wire  qyt_pkg::cmd_t  cmd,
  output qyt_pkg::stat_t       stat,
  input  wire                  cfg_valid,
  input  wire  [15:0]          cfg_data,
  input  wire  signed [31:0]   quat_x,
  input  wire  signed [31:0]   quat_y,
  input  wire  signed [31:0]   quat_z,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic signed [31:0]   heading,
  output logic [15:0]          current_yaw
);
  import qyt_pkg::*;

  logic [15:0]        dead_band;
  logic [15:0]        latest_yaw;
  logic [15:0]        previous_yaw;
  logic signed [31:0] tracked;

  logic signed [31:0] qx, qy, qz;
  logic signed [63:0] prod;
  logic [63:0]        ssum, qsum;
  logic signed [63:0] num;
  logic [60:0]        rad, root, rbit;
  logic signed [59:0] numa, dena;
  logic signed [62:0] cx, cy;
  logic signed [25:0] ang;
  logic               zv;

  logic signed [32:0] ma, mb;
  logic signed [65:0] mprod;
  logic [61:0]        tsum;
  logic signed [63:0] numf, denf;
  logic signed [62:0] dx, dy;
  logic signed [25:0] tbl;
  logic signed [26:0] vs;
  logic [25:0]        vc;
  logic [17:0]        vr;
  logic signed [16:0] d, mag;
  logic signed [33:0] t;
  logic signed [31:0] tsat;

  always_comb begin
    ma = {qx[31], qx};
    mb = {qy[31], qy};
    if (cmd.op == OP_WMUL) begin
      ma = {2'b00, root[30:0]};
      mb = {qz[31], qz};
    end else begin
      case (cmd.step[1:0])
        2'd0: begin ma = {qx[31], qx}; mb = {qx[31], qx}; end
        2'd1: begin ma = {qy[31], qy}; mb = {qy[31], qy}; end
        2'd2: begin ma = {qz[31], qz}; mb = {qz[31], qz}; end
        default: begin ma = {qx[31], qx}; mb = {qy[31], qy}; end
      endcase
    end
    mprod = ma * mb;
    tsum  = {1'b0, root} + {1'b0, rbit};
    numf  = num + prod;
    denf  = $signed(ONE_Q59 - qsum);
    dx    = cy >>> cmd.step;
    dy    = cx >>> cmd.step;
    tbl   = $signed({2'b00, ATAN_TBL[cmd.step]});
    vs    = (zv ? 27'sd0 : 27'(ang)) + ANG_180;
    vc    = vs[26] ? 26'd0 : vs[25:0];
    vr    = 18'((27'(vc) + 27'd256) >> 9);
    d     = $signed({1'b0, previous_yaw}) - $signed({1'b0, latest_yaw});
    mag   = d[16] ? -d : d;
    if (34'(tracked) < 34'(d)) t = 34'(d) - 34'(tracked);
    else t = 34'(tracked) - 34'(d);
    if (t > 34'sd2147483647) tsat = 32'sh7fffffff;
    else if (t < -34'sd2147483648) tsat = 32'sh80000000;
    else tsat = t[31:0];
  end

  assign stat.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_band    <= 16'd13;
      latest_yaw   <= '0;
      previous_yaw <= YAW_HALF;
      tracked      <= 32'(YAW_HALF);
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) dead_band <= cfg_data;
      if (cmd.emit) begin
        if ($unsigned(mag) > {1'b0, dead_band}) begin
          tracked <= tsat;
          heading <= tsat;
        end else begin
          heading <= tracked;
        end
        current_yaw  <= latest_yaw;
        previous_yaw <= latest_yaw;
        out_valid    <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.op == OP_FIN) latest_yaw <= (vr > YAW_MAX) ? 16'(YAW_MAX) : vr[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx <= quat_x;
      qy <= quat_y;
      qz <= quat_z;
    end
    unique case (cmd.op)
      OP_MUL: begin
        if (cmd.step != 5'd4) prod <= mprod[63:0];
        case (cmd.step)
          5'd1: ssum <= prod;
          5'd2: begin ssum <= ssum + prod; qsum <= prod; end
          5'd3: begin ssum <= ssum + prod; qsum <= qsum + prod; end
          5'd4: num <= prod;
          default: ;
        endcase
      end
      OP_RINIT: begin
        rad  <= (ssum >= ONE_Q60) ? 61'd0 : 61'(ONE_Q60 - ssum);
        root <= '0;
        rbit <= 61'd1 << 60;
      end
      OP_ROOT: begin
        if ({1'b0, rad} >= tsum) begin
          rad  <= rad - tsum[60:0];
          root <= (root >> 1) + rbit;
        end else begin
          root <= root >> 1;
        end
        rbit <= rbit >> 2;
      end
      OP_WMUL: prod <= mprod[63:0];
      OP_OPER: begin
        numa <= 60'(numf >>> 4);
        dena <= 60'(denf >>> 4);
      end
      OP_CINIT: begin
        zv <= (numa == 60'sd0) && (dena == 60'sd0);
        if (dena < 0) begin
          if (numa >= 0) begin
            cx <= 63'(numa); cy <= -63'(dena); ang <= ANG_90;
          end else begin
            cx <= -63'(numa); cy <= 63'(dena); ang <= -ANG_90;
          end
        end else begin
          cx <= 63'(dena); cy <= 63'(numa); ang <= '0;
        end
      end
      OP_CORDIC: begin
        if (cy > 0) begin
          cx <= cx + dx; cy <= cy - dy; ang <= ang + tbl;
        end else begin
          cx <= cx - dx; cy <= cy + dy; ang <= ang - tbl;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[hdl/qyt_ctrl.sv]
// ----------------------------------------------------------------------------
// Quaternion yaw tracker controller
// Sequences one quaternion request through multiply, root, CORDIC and finish.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quaternion_yaw_tracker_defines.svh"

module qyt_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire  [1:0]           fifo_status,
  input  wire                  has_quat6,
  input  wire  qyt_pkg::stat_t stat,
  output qyt_pkg::cmd_t        cmd
);
  import qyt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_RINIT, S_ROOT, S_WMUL, S_OPER, S_CINIT, S_CORDIC, S_FIN
  } state_t;

  localparam logic [4:0] LAST_CORDIC = 5'(CORDIC_STEPS - 1);

  state_t     state;
  logic [4:0] cnt;
  logic       accept;

  assign in_stall = (state != S_IDLE) || stat.out_busy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd.step  = cnt;
    cmd.start = accept && (fifo_status == ST_DATA) && has_quat6;
    cmd.emit  = accept && (fifo_status == ST_EMPTY);
    unique case (state)
      S_IDLE:   cmd.op = OP_IDLE;
      S_MUL:    cmd.op = OP_MUL;
      S_RINIT:  cmd.op = OP_RINIT;
      S_ROOT:   cmd.op = OP_ROOT;
      S_WMUL:   cmd.op = OP_WMUL;
      S_OPER:   cmd.op = OP_OPER;
      S_CINIT:  cmd.op = OP_CINIT;
      S_CORDIC: cmd.op = OP_CORDIC;
      S_FIN:    cmd.op = OP_FIN;
      default:  cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (cmd.start) state <= S_MUL;
        end
        S_MUL: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd4) state <= S_RINIT;
        end
        S_RINIT: begin
          cnt   <= '0;
          state <= S_ROOT;
        end
        S_ROOT: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd30) state <= S_WMUL;
        end
        S_WMUL:  state <= S_OPER;
        S_OPER:  state <= S_CINIT;
        S_CINIT: begin
          cnt   <= '0;
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          cnt <= cnt + 5'd1;
          if (cnt == LAST_CORDIC) state <= S_FIN;
        end
        S_FIN:   state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `QYT_ASSERT_NEXT(a_start_busy, clk, rst, cmd.start, state == S_MUL, "start did not enter multiply")
  `QYT_ASSERT_NOW(a_busy_stall, clk, rst, state != S_IDLE, in_stall, "busy without stall")
  `QYT_ASSERT_NOW(a_emit_idle, clk, rst, cmd.emit, state == S_IDLE && !stat.out_busy, "emit while busy")
  `QYT_ASSERT_NEXT(a_fin_idle, clk, rst, state == S_FIN, state == S_IDLE, "finish did not return")

endmodule

`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Quaternion yaw tracker testbench
// Drives quaternion, empty and ignored FIFO requests through the tracker under
// several stall patterns and dead-band settings. A scoreboard predicts the yaw
// and heading of each empty request and checks them against the results.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import qyt_pkg::*;

  localparam logic [1:0] ST_OTHER  = 2'd1;
  localparam logic [1:0] ST_UNUSED = 2'd3;
  localparam int STEPS     = 16;
  localparam int DRAIN     = 80;
  localparam int WD_LIMIT  = 5000;
  localparam int HOLD_LEN  = 400;
  localparam int N_RANDOM  = 1000;

  class yaw_scoreboard;
    int unsigned dead_band;
    longint latest, previous, track;
    longint exp_heading[$];
    longint exp_yaw[$];

    function void reset_state();
      dead_band = 13;
      latest = 0;
      previous = longint'(YAW_HALF);
      track = longint'(YAW_HALF);
      exp_heading.delete();
      exp_yaw.delete();
    endfunction

    function longint unsigned root64(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint arctan_deg(longint num, longint den);
      longint x, y, ang, dx, dy;
      if (num == 0 && den == 0) return 0;
      if (den < 0) begin
        if (num >= 0) begin
          x = num; y = -den; ang = 64'sd90 <<< 16;
        end else begin
          x = -num; y = den; ang = -(64'sd90 <<< 16);
        end
      end else begin
        x = den; y = num; ang = 0;
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x = x + dx; y = y - dy; ang = ang + longint'(ATAN_TBL[i]);
        end else begin
          x = x - dx; y = y + dy; ang = ang - longint'(ATAN_TBL[i]);
        end
      end
      return ang;
    endfunction

    function void yaw_from_quat(longint qx, longint qy, longint qz);
      longint unsigned xx, yy, zz, s, w2, q;
      longint w, num, den, v;
      xx = qx * qx;
      yy = qy * qy;
      zz = qz * qz;
      s = xx + yy + zz;
      w2 = (s >= ONE_Q60) ? 64'd0 : ONE_Q60 - s;
      w = root64(w2);
      num = qx * qy + w * qz;
      q = yy + zz;
      if (q <= ONE_Q59) den = ONE_Q59 - q;
      else den = -longint'(q - ONE_Q59);
      v = arctan_deg(num >>> 4, den >>> 4) + (64'sd180 <<< 16);
      if (v < 0) v = 0;
      v = (v + 256) >>> 9;
      if (v > 46080) v = 46080;
      latest = v;
    endfunction

    function void note_request(logic [1:0] st, logic hq, logic signed [31:0] x,
                               logic signed [31:0] y, logic signed [31:0] z);
      longint d, mag, t;
      if (st == ST_DATA) begin
        if (hq) yaw_from_quat(longint'(x), longint'(y), longint'(z));
      end else if (st == ST_EMPTY) begin
        d = previous - latest;
        mag = d < 0 ? -d : d;
        if (mag > dead_band) begin
          t = (track < d) ? d - track : track - d;
          if (t > 64'sd2147483647) t = 64'sd2147483647;
          if (t < -64'sd2147483648) t = -64'sd2147483648;
          track = t;
        end
        previous = latest;
        exp_heading.push_back(track);
        exp_yaw.push_back(latest);
      end
    endfunction

    function string check_result(logic signed [31:0] hd, logic [15:0] cy);
      longint eh, ey;
      if (exp_heading.size() == 0)
        return $sformatf("unexpected result heading=%0d yaw=%0d", hd, cy);
      eh = exp_heading.pop_front();
      ey = exp_yaw.pop_front();
      if (longint'(hd) != eh || longint'(cy) != ey)
        return $sformatf("heading %0d/%0d yaw %0d/%0d (got/exp)", hd, eh, cy, ey);
      return "";
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall;
  logic [1:0] fifo_status;
  logic has_quat6;
  logic signed [31:0] quat_x, quat_y, quat_z;
  logic out_valid, out_stall;
  logic signed [31:0] heading;
  logic [15:0] current_yaw;
  logic cfg_valid, cfg_ready;
  logic [15:0] cfg_data;

  yaw_scoreboard sb;
  int errors = 0;
  int n_results = 0;
  int n_requests = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left;
  logic hold_req;
  logic hold_taken;
  int idle_count = 0;

  quaternion_yaw_tracker #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .fifo_status(fifo_status), .has_quat6(has_quat6),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .heading(heading), .current_yaw(current_yaw),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task report(string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // result monitor and receiver stall
  always @(posedge clk) begin
    string msg;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      msg = sb.check_result(heading, current_yaw);
      if (msg != "") report(msg);
    end
    if (rst) begin
      out_stall  <= 1'b0;
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_LEN - 1;
      out_stall  <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on progress
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= WD_LIMIT) begin
        $display("Watchdog timeout at %0t", $time);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task send(logic [1:0] st, logic hq, logic signed [31:0] x, logic signed [31:0] y,
            logic signed [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    fifo_status <= st;
    has_quat6 <= hq;
    quat_x <= x;
    quat_y <= y;
    quat_z <= z;
    do @(posedge clk); while (in_stall);
    sb.note_request(st, hq, x, y, z);
    n_requests++;
  endtask

  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.exp_heading.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task write_band(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.dead_band = 32'(v);
  endtask

  task quat_request(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
    send(ST_DATA, 1'b1, x, y, z);
    send(ST_EMPTY, 1'($urandom), $urandom, $urandom, $urandom);
  endtask

  function logic signed [31:0] rand_comp(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(32'h2000_0000 * 2)) - 32'sh2000_0000;
      default: return $signed($urandom_range(32'h0010_0000 * 2)) - 32'sh0010_0000;
    endcase
  endfunction

  task random_phase(int count);
    int k, m;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      m = $urandom_range(9) < 2 ? 0 : ($urandom_range(3) == 0 ? 2 : 1);
      if (k < 45)
        send(ST_DATA, 1'b1, rand_comp(m), rand_comp(m), rand_comp(m));
      else if (k < 80)
        send(ST_EMPTY, 1'($urandom), $urandom, $urandom, $urandom);
      else if (k < 88)
        send(ST_DATA, 1'b0, $urandom, $urandom, $urandom);
      else
        send(($urandom_range(1) ? ST_OTHER : ST_UNUSED), 1'($urandom), $urandom,
             $urandom, $urandom);
    end
  endtask

  initial begin
    logic [15:0] bands[5];
    int idle_s[4], idle_r[4];
    bands = '{16'd0, 16'd46080, 16'd13, 16'd1000, 16'hFFFF};
    idle_s = '{0, 53, 0, 23};
    idle_r = '{0, 0, 53, 23};
    sb = new();
    sb.reset_state();
    rst = 1'b1;
    hold_req = 1'b0;
    in_valid = 1'b0; fifo_status = ST_OTHER; has_quat6 = 1'b0;
    quat_x = 0; quat_y = 0; quat_z = 0;
    cfg_valid = 1'b0; cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset band first
    send(ST_EMPTY, 1'b0, 0, 0, 0);
    quat_request(0, 0, 0);
    quat_request(-32'sh2000_0000, 32'sh2000_0000, 32'sh2000_0000);
    quat_request(0, 32'sh4000_0000, 32'sh4000_0000);
    quat_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    quat_request(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    quat_request(0, 0, 32'sh4000_0000);
    quat_request(0, 0, -32'sh4000_0000);
    quat_request(32'sh2000_0000, -32'sh1000_0000, 32'sh0100_0000);
    send(ST_DATA, 1'b0, 32'sh1234_5678, 0, 0);
    send(ST_OTHER, 1'b1, 32'sh4000_0000, 0, 0);
    send(ST_UNUSED, 1'b1, 0, 32'sh4000_0000, 0);
    send(ST_EMPTY, 1'b1, 0, 0, 0);
    quat_request(0, 0, 32'sh0000_1000);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_band(bands[p]);
      send_idle_pct = idle_s[p % 4];
      recv_stall_pct = idle_r[p % 4];
      if (p == 2) hold_req = 1'b1;
      random_phase(N_RANDOM / 5);
      drain();
    end

    $display("Sent %0d requests, checked %0d results over 5 dead-band settings",
             n_requests, n_results);
    $display("and four stall patterns with one long receiver hold-off.");
    if (errors == 0 && sb.exp_heading.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, sb.exp_heading.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
